>>> rtl/amb_pkg.sv
package amb_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;

   // Internal widths: CORDIC datapath, reduced angle and translated term.
   localparam int XW = 36;
   localparam int UW = 36;

   // Pipeline depths of the units.
   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int ROT_LAT    = 4;
   localparam int LANE_LAT   = 4;
   localparam int DLY_LAT    = CORDIC_LAT + ROT_LAT;
   localparam int TOTAL_LAT  = 1 + DLY_LAT + LANE_LAT;

   // Constants in Q28 and Q30.
   localparam logic signed [XW-1:0] PI_Q28      = XW'(64'sd843314857);
   localparam logic signed [XW-1:0] HALF_PI_Q28 = XW'(64'sd421657428);
   localparam logic signed [XW-1:0] GAIN_Q30    = XW'(64'sd652032874);
   localparam logic signed [XW-1:0] ONE_Q30     = XW'(64'sd1073741824);

   localparam logic [1:0] LAST_ROW = 2'd3;

   typedef logic signed [31:0] q30_type;
   typedef logic signed [31:0] elem_type;

   // Arctangent of 2^-i in Q28.
   function automatic logic signed [XW-1:0] atan_q28(input int i);
      logic signed [XW-1:0] r;
      begin
         unique case (i)
            0:  r = XW'(64'sd210828714);
            1:  r = XW'(64'sd124459457);
            2:  r = XW'(64'sd65760959);
            3:  r = XW'(64'sd33381290);
            4:  r = XW'(64'sd16755422);
            5:  r = XW'(64'sd8385879);
            6:  r = XW'(64'sd4193963);
            7:  r = XW'(64'sd2097109);
            8:  r = XW'(64'sd1048571);
            9:  r = XW'(64'sd524287);
            10: r = XW'(64'sd262144);
            11: r = XW'(64'sd131072);
            12: r = XW'(64'sd65536);
            13: r = XW'(64'sd32768);
            14: r = XW'(64'sd16384);
            15: r = XW'(64'sd8192);
            16: r = XW'(64'sd4096);
            17: r = XW'(64'sd2048);
            18: r = XW'(64'sd1024);
            19: r = XW'(64'sd512);
            20: r = XW'(64'sd256);
            21: r = XW'(64'sd128);
            22: r = XW'(64'sd64);
            default: r = XW'(64'sd32);
         endcase
         return r;
      end
   endfunction

   // Round half away from zero by 30 bits, clamp to [-1.0, 1.0] in Q30.
   function automatic q30_type rnd_q30(input logic signed [65:0] acc);
      logic signed [65:0] r;
      begin
         r = acc + (66'sd1 <<< 29);
         if (acc[65]) begin
            r = r - 66'sd1;
         end
         r = r >>> 30;
         if (r > 66'sd1073741824) begin
            r = 66'sd1073741824;
         end else if (r < -66'sd1073741824) begin
            r = -66'sd1073741824;
         end
         return r[31:0];
      end
   endfunction

   // Round half away from zero by sh bits, saturate to 32-bit signed.
   function automatic elem_type rnd_sat(input logic signed [67:0] v, input int sh);
      logic signed [67:0] r;
      begin
         r = v + (68'sd1 <<< (sh - 1));
         if (v[67]) begin
            r = r - 68'sd1;
         end
         r = r >>> sh;
         if (r > 68'sd2147483647) begin
            r = 68'sd2147483647;
         end else if (r < -68'sd2147483648) begin
            r = -68'sd2147483648;
         end
         return r[31:0];
      end
   endfunction

endpackage

>>> rtl/amb_cordic.sv
module amb_cordic
   import amb_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] angle_i,
   output q30_type            sin_o,
   output q30_type            cos_o
);

   logic signed [XW-1:0] z_wide;
   logic signed [XW-1:0] z_red;
   logic                 neg_red;

   logic signed [XW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] z_ff [CORDIC_STAGES+1];
   logic                 neg_ff [CORDIC_STAGES+1];

   logic signed [XW-1:0] x_fin;
   logic signed [XW-1:0] y_fin;
   q30_type              sin_ff;
   q30_type              cos_ff;

   // Widen Q3.12 to Q28 and fold the angle into [-pi/2, pi/2]; an odd
   // number of pi steps flips the sign of both outputs.
   assign z_wide = {{(XW-32){angle_i[15]}}, angle_i, 16'd0};

   always_comb begin
      logic signed [XW-1:0] cand;
      cand    = z_wide;
      z_red   = z_wide;
      neg_red = 1'b0;
      for (int k = -3; k <= 3; k++) begin
         cand = z_wide - XW'(k) * PI_Q28;
         if ((cand >= -HALF_PI_Q28) && (cand <= HALF_PI_Q28)) begin
            z_red   = cand;
            neg_red = k[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_red;
         neg_ff[0] <= neg_red;
      end
   end

   // One micro-rotation per pipeline stage.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][XW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q28(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q28(i);
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // Apply the folding sign and clamp to unit range.
   always_comb begin
      x_fin = neg_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      y_fin = neg_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
      if (x_fin > ONE_Q30) begin
         x_fin = ONE_Q30;
      end else if (x_fin < -ONE_Q30) begin
         x_fin = -ONE_Q30;
      end
      if (y_fin > ONE_Q30) begin
         y_fin = ONE_Q30;
      end else if (y_fin < -ONE_Q30) begin
         y_fin = -ONE_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= x_fin[31:0];
         sin_ff <= y_fin[31:0];
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

>>> rtl/amb_rotate.sv
module amb_rotate
   import amb_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  q30_type sin_i [3],
   input  q30_type cos_i [3],
   output q30_type rot_o [3][3]
);

   // First product: Rz * Ry, only its nonzero terms.
   logic signed [63:0] czcy_ff, czsy_ff, szcy_ff, szsy_ff;
   q30_type            sz1_ff, cz1_ff, sy1_ff, cy1_ff, sx1_ff, cx1_ff;

   q30_type            rzy_ff [3][3];
   q30_type            sx2_ff, cx2_ff;

   logic signed [63:0] pa_ff [3][4];
   q30_type            c0_ff [3];

   q30_type            rot_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         czcy_ff <= cos_i[2] * cos_i[1];
         czsy_ff <= cos_i[2] * sin_i[1];
         szcy_ff <= sin_i[2] * cos_i[1];
         szsy_ff <= sin_i[2] * sin_i[1];
         sz1_ff  <= sin_i[2];
         cz1_ff  <= cos_i[2];
         sy1_ff  <= sin_i[1];
         cy1_ff  <= cos_i[1];
         sx1_ff  <= sin_i[0];
         cx1_ff  <= cos_i[0];
      end
   end

   // Round the Rz * Ry entries; unit terms pass through exactly.
   always_ff @(posedge clock) begin
      if (en) begin
         rzy_ff[0][0] <= rnd_q30(66'(czcy_ff));
         rzy_ff[0][1] <= -sz1_ff;
         rzy_ff[0][2] <= rnd_q30(66'(czsy_ff));
         rzy_ff[1][0] <= rnd_q30(66'(szcy_ff));
         rzy_ff[1][1] <= cz1_ff;
         rzy_ff[1][2] <= rnd_q30(66'(szsy_ff));
         rzy_ff[2][0] <= -sy1_ff;
         rzy_ff[2][1] <= '0;
         rzy_ff[2][2] <= cy1_ff;
         sx2_ff       <= sx1_ff;
         cx2_ff       <= cx1_ff;
      end
   end

   // Second product: (Rz * Ry) * Rx; column 0 is unchanged.
   for (genvar i = 0; i < 3; i++) begin : g_row
      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff[i][0] <= rzy_ff[i][1] * cx2_ff;
            pa_ff[i][1] <= rzy_ff[i][2] * sx2_ff;
            pa_ff[i][2] <= rzy_ff[i][1] * sx2_ff;
            pa_ff[i][3] <= rzy_ff[i][2] * cx2_ff;
            c0_ff[i]    <= rzy_ff[i][0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rot_ff[i][0] <= c0_ff[i];
            rot_ff[i][1] <= rnd_q30(66'(pa_ff[i][0]) + 66'(pa_ff[i][1]));
            rot_ff[i][2] <= rnd_q30(66'(pa_ff[i][3]) - 66'(pa_ff[i][2]));
         end
      end

      for (genvar j = 0; j < 3; j++) begin : g_col
         assign rot_o[i][j] = rot_ff[i][j];
      end
   end

endmodule

>>> rtl/amb_col_lane.sv
module amb_col_lane
   import amb_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  q30_type            rot_col_i [3],
   input  logic signed [31:0] scale_i,
   input  logic signed [31:0] shift_i [3],
   output elem_type           elem_o [4]
);

   logic signed [63:0] pr_ff [3];
   logic signed [63:0] pt_ff [3];
   logic signed [31:0] sc1_ff, sc2_ff;

   elem_type           ma_ff [3];
   elem_type           mb_ff [3];
   elem_type           mc_ff [3];
   logic signed [UW-1:0] u_ff;
   logic signed [67:0] pu_ff;
   elem_type           m3_ff;

   logic signed [65:0] tacc;
   logic signed [65:0] tr;

   // Scale products for rows 0..2 and translation products for row 3.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= rot_col_i[i] * scale_i;
            pt_ff[i] <= shift_i[i] * rot_col_i[i];
         end
         sc1_ff <= scale_i;
      end
   end

   // Translated term, rounded once and left unsaturated.
   always_comb begin
      tacc = 66'(pt_ff[0]) + 66'(pt_ff[1]) + 66'(pt_ff[2]);
      tr   = tacc + (66'sd1 <<< 29);
      if (tacc[65]) begin
         tr = tr - 66'sd1;
      end
      tr = tr >>> 30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ma_ff[i] <= rnd_sat(68'(pr_ff[i]), 30);
         end
         u_ff   <= tr[UW-1:0];
         sc2_ff <= sc1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb_ff <= ma_ff;
         pu_ff <= 68'(u_ff) * 68'(sc2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mc_ff <= mb_ff;
         m3_ff <= rnd_sat(pu_ff, FRAC_BITS);
      end
   end

   assign elem_o[0] = mc_ff[0];
   assign elem_o[1] = mc_ff[1];
   assign elem_o[2] = mc_ff[2];
   assign elem_o[3] = m3_ff;

endmodule

>>> rtl/affine_matrix_builder_unit.sv
// Builds M = T * R * S from one beat holding scale, three angles (Q3.12 radians) and a
// translation, all Q16.16 but the angles, and returns M as four beats, rows 0 to 3, each
// with elements in columns 0 to 3 saturated to 32 bits. Three CORDIC lanes form sine and
// cosine, a pipelined unit forms the rotation, and three column lanes apply scale and
// translation. A new item can enter every cycle while the output buffer is free; a finished
// matrix holds the buffer until all four of its row beats are taken, and the whole pipeline
// stalls until its last row is taken, so each matrix costs the pipeline four row beats.
module affine_matrix_builder_unit
   import amb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
   input  logic [239:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // elem0, elem1, elem2, elem3
   output logic [127:0]  rsp_tdata,
   // row_index
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   logic               en;
   logic               vld_ff [TOTAL_LAT];

   logic signed [31:0] sc_ff [3];
   logic signed [15:0] ang_ff [3];
   logic signed [31:0] sh_ff [3];

   logic signed [31:0] sc_dly_ff [DLY_LAT][3];
   logic signed [31:0] sh_dly_ff [DLY_LAT][3];

   q30_type            sin_w [3];
   q30_type            cos_w [3];
   q30_type            rot_w [3][3];
   q30_type            rot_col_w [3][3];
   elem_type           col_w [3][4];

   logic               hold_vld_ff;
   elem_type           hold_ff [4][4];
   logic [1:0]         row_ff;

   // The whole pipeline advances unless a finished matrix is still draining.
   assign en         = !hold_vld_ff || (rsp_tready && (row_ff == LAST_ROW));
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < TOTAL_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Input beat register.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sc_ff[i]  <= req_tdata[32*i +: 32];
            ang_ff[i] <= req_tdata[96 + 16*i +: 16];
            sh_ff[i]  <= req_tdata[144 + 32*i +: 32];
         end
      end
   end

   // Scale and shift wait for the rotation.
   always_ff @(posedge clock) begin
      if (en) begin
         sc_dly_ff[0] <= sc_ff;
         sh_dly_ff[0] <= sh_ff;
         for (int k = 1; k < DLY_LAT; k++) begin
            sc_dly_ff[k] <= sc_dly_ff[k-1];
            sh_dly_ff[k] <= sh_dly_ff[k-1];
         end
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_cordic
      amb_cordic u_cordic (
         .clock   (clock),
         .en      (en),
         .angle_i (ang_ff[a]),
         .sin_o   (sin_w[a]),
         .cos_o   (cos_w[a])
      );
   end

   amb_rotate u_rotate (
      .clock (clock),
      .en    (en),
      .sin_i (sin_w),
      .cos_i (cos_w),
      .rot_o (rot_w)
   );

   for (genvar j = 0; j < 3; j++) begin : g_lane
      for (genvar i = 0; i < 3; i++) begin : g_pick
         assign rot_col_w[j][i] = rot_w[i][j];
      end

      amb_col_lane u_lane (
         .clock     (clock),
         .en        (en),
         .rot_col_i (rot_col_w[j]),
         .scale_i   (sc_dly_ff[DLY_LAT-1][j]),
         .shift_i   (sh_dly_ff[DLY_LAT-1]),
         .elem_o    (col_w[j])
      );
   end

   // Merge the column lanes into one matrix and hold it for the row beats.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
               hold_ff[i][j] <= col_w[j][i];
            end
            hold_ff[i][3] <= (i == 3) ? elem_type'(1 << FRAC_BITS) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         row_ff      <= '0;
      end else begin
         if (en) begin
            hold_vld_ff <= vld_ff[TOTAL_LAT-1];
         end
         if (rsp_tvalid && rsp_tready) begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   assign rsp_tvalid = hold_vld_ff;
   assign rsp_tdata  = {hold_ff[row_ff][3], hold_ff[row_ff][2],
                        hold_ff[row_ff][1], hold_ff[row_ff][0]};
   assign rsp_tuser  = row_ff;
   assign rsp_tlast  = (row_ff == LAST_ROW);

   // An empty output buffer always starts again at row 0.
   a_row_idle: assert property (@(posedge clock) disable iff (reset)
      !hold_vld_ff |-> (row_ff == 2'd0))
      else $error("row counter not at zero while buffer empty");

   // A finished matrix reaches the buffer when the pipeline advances.
   a_load: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[TOTAL_LAT-1]) |=> hold_vld_ff)
      else $error("finished matrix lost at output buffer");

   // Column 3 is zero on rows 0 to 2.
   a_col3: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (row_ff != LAST_ROW)) |-> (rsp_tdata[127:96] == 32'd0))
      else $error("column 3 nonzero outside the last row");

endmodule
